>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the top level and the shift unit of the digit arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

>>> hw/rtl/mda_pkg.sv
// Types and constants shared by the multiprecision digit arithmetic unit.
`timescale 1ns / 1ps

package mda_pkg;

    localparam int DIGIT_W = 8;

    // Operation codes.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_NEG = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic               first;
        logic               last;
        logic [DIGIT_W-1:0] digit_x;
        logic [DIGIT_W-1:0] operand_y;
        logic [DIGIT_W-1:0] carry_in;
    } t_in;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit_z;
        logic [DIGIT_W-1:0] carry_out;
        logic               last_out;
        logic               div_error;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SERIAL,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_ser_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ser_sts;

endpackage

>>> hw/rtl/multiprecision_digit_alu.sv
// Top level of the multiprecision base-256 digit arithmetic unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Each input beat carries one base-256 digit of a multi-digit operand together with
// the operation, first/last marks, the second operand digit or byte scalar, and an
// initial carry. The unit keeps a running carry, borrow or remainder between beats:
// the beat marked first reloads it (carry_in for add, subtract and negate, zero for
// multiply and divide), and every beat yields one output beat with the result digit
// and the updated carry, which on the last beat is the value of the whole operation.
// Divide digits are fed most significant first, the other operations least
// significant first. A zero divisor gives digit 255, raises div_error and leaves the
// remainder unchanged. One item is processed at a time. Add, subtract, negate, a
// zero-divisor divide and an unused op code go from the idle state straight to the
// write state, which moves the result into the output register once it is free.
// Multiply and divide pass through the serial state first: the shift-add multiplier
// consumes one scalar bit per cycle over 8 steps, and the restoring divider produces
// one quotient bit per cycle over 16 steps; the serial unit then signals done and
// the write state writes the result. The next item is accepted as soon as the
// previous result has moved into the output register and the unit is back in idle,
// so a stalled output holds the unit back only when a second result is ready
// behind it.
module multiprecision_digit_alu (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mda_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mda_pkg::t_out  o_out_data
);
    import mda_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [DIGIT_W-1:0] r_carry;
    logic               r_out_valid;
    t_out               r_out;

    // Captured item, held while it is worked on.
    logic [2:0]         r_op;
    logic               r_last;
    logic [DIGIT_W-1:0] r_x;
    logic [DIGIT_W-1:0] r_y;
    logic [DIGIT_W-1:0] r_c;

    logic               in_acc;
    logic               out_free;
    logic               write_res;
    logic [DIGIT_W-1:0] c_eff;
    t_ser_ctrl          ser_ctrl;
    t_ser_sts           ser_sts;
    logic [DIGIT_W-1:0] ser_digit;
    logic [DIGIT_W-1:0] ser_carry;
    logic [DIGIT_W-1:0] add_digit;
    logic [DIGIT_W-1:0] add_carry;
    t_out               result;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Starting carry: reloaded on a first beat of a known op, otherwise the held state.
    always_comb begin
        if (i_in_data.first && (i_in_data.op <= OP_DIV)) begin
            c_eff = (i_in_data.op <= OP_NEG) ? i_in_data.carry_in : '0;
        end else begin
            c_eff = r_carry;
        end
    end

    // Sequencer: next state and control.
    always_comb begin
        n_state         = r_state;
        ser_ctrl.start  = 1'b0;
        ser_ctrl.is_div = (i_in_data.op == OP_DIV);
        write_res       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if ((i_in_data.op == OP_MUL) ||
                        ((i_in_data.op == OP_DIV) && (i_in_data.operand_y != '0))) begin
                        ser_ctrl.start = 1'b1;
                        n_state        = ST_SERIAL;
                    end else begin
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_SERIAL: begin
                if (ser_sts.done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    write_res = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_in_data.op;
            r_last <= i_in_data.last;
            r_x    <= i_in_data.digit_x;
            r_y    <= i_in_data.operand_y;
            r_c    <= c_eff;
        end
    end

    mda_shift_unit u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ser_ctrl),
        .i_x     (i_in_data.digit_x),
        .i_y     (i_in_data.operand_y),
        .i_c     (c_eff),
        .o_sts   (ser_sts),
        .o_digit (ser_digit),
        .o_carry (ser_carry)
    );

    mda_digit_add u_add (
        .i_op    (r_op),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_c     (r_c),
        .o_digit (add_digit),
        .o_carry (add_carry)
    );

    // Result selection. Unused op codes fall to the adder, which gives digit zero
    // and passes the held carry through.
    always_comb begin
        result.last_out  = r_last;
        result.div_error = 1'b0;
        case (r_op) inside
            OP_MUL: begin
                result.digit_z   = ser_digit;
                result.carry_out = ser_carry;
            end
            OP_DIV: begin
                if (r_y == '0) begin
                    result.digit_z   = '1;
                    result.carry_out = r_c;
                    result.div_error = 1'b1;
                end else begin
                    result.digit_z   = ser_digit;
                    result.carry_out = ser_carry;
                end
            end
            default: begin
                result.digit_z   = add_digit;
                result.carry_out = add_carry;
            end
        endcase
    end

    // Running carry and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (write_res) begin
                r_carry     <= result.carry_out;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (write_res) begin
            r_out <= result;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_CLK(a_serial_in_state, i_clk, i_rst_n, (ser_sts.busy || ser_sts.done) |-> (r_state == ST_SERIAL), "serial unit active outside its state")
    `ASSERT_CLK(a_zero_div_direct, i_clk, i_rst_n, (in_acc && (i_in_data.op == OP_DIV) && (i_in_data.operand_y == '0)) |=> (r_state == ST_WRITE), "zero divisor entered serial unit")
    `ASSERT_NEVER(a_add_carry_small, i_clk, i_rst_n, write_res && ((r_op == OP_ADD) || (r_op == OP_SUB)) && (result.carry_out > 8'd2), "add or subtract carry above two")

endmodule

>>> hw/rtl/mda_digit_add.sv
// Combinational digit adder for add with carry, subtract with borrow and negate.
`timescale 1ns / 1ps

module mda_digit_add (
    input  logic [2:0]                  i_op,
    input  logic [mda_pkg::DIGIT_W-1:0] i_x,
    input  logic [mda_pkg::DIGIT_W-1:0] i_y,
    input  logic [mda_pkg::DIGIT_W-1:0] i_c,
    output logic [mda_pkg::DIGIT_W-1:0] o_digit,
    output logic [mda_pkg::DIGIT_W-1:0] o_carry
);
    import mda_pkg::*;

    logic [DIGIT_W+1:0] sum3;
    logic [DIGIT_W+1:0] diff;
    logic [1:0]         borrow;
    logic [DIGIT_W:0]   negs;

    always_comb begin
        sum3   = {2'b00, i_x} + {2'b00, i_y} + {2'b00, i_c};
        // The offset of three digit weights keeps the difference non-negative.
        diff   = 10'd768 + {2'b00, i_x} - {2'b00, i_y} - {2'b00, i_c};
        borrow = 2'd3 - diff[DIGIT_W+1:DIGIT_W];
        negs   = {1'b0, i_c} + {1'b0, ~i_x};

        case (i_op)
            OP_ADD: begin
                o_digit = sum3[DIGIT_W-1:0];
                o_carry = {6'b0, sum3[DIGIT_W+1:DIGIT_W]};
            end
            OP_SUB: begin
                o_digit = diff[DIGIT_W-1:0];
                o_carry = {6'b0, borrow};
            end
            OP_NEG: begin
                o_digit = negs[DIGIT_W-1:0];
                o_carry = {7'b0, negs[DIGIT_W]};
            end
            default: begin
                o_digit = '0;
                o_carry = i_c;
            end
        endcase
    end

endmodule

>>> hw/rtl/mda_shift_unit.sv
// Bit-serial shift-add multiplier and restoring divider for one digit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mda_shift_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mda_pkg::t_ser_ctrl          i_ctrl,
    input  logic [mda_pkg::DIGIT_W-1:0] i_x,
    input  logic [mda_pkg::DIGIT_W-1:0] i_y,
    input  logic [mda_pkg::DIGIT_W-1:0] i_c,
    output mda_pkg::t_ser_sts           o_sts,
    output logic [mda_pkg::DIGIT_W-1:0] o_digit,
    output logic [mda_pkg::DIGIT_W-1:0] o_carry
);
    import mda_pkg::*;

    localparam int MUL_STEPS = DIGIT_W;
    localparam int DIV_STEPS = 2 * DIGIT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_is_div;
    logic [CNT_W-1:0]     r_cnt;
    logic [2*DIGIT_W-1:0] r_acc;
    logic [2*DIGIT_W-1:0] r_mcand;
    logic [DIGIT_W-1:0]   r_y;
    logic [DIGIT_W-1:0]   r_rem;
    logic [DIGIT_W-1:0]   r_q;

    logic [DIGIT_W:0]     rem_ext;
    logic [DIGIT_W:0]     rem_sub;
    logic                 rem_ge;
    logic [2*DIGIT_W-1:0] mul_sum;
    logic                 last_step;

    always_comb begin
        rem_ext   = {r_rem, r_acc[2*DIGIT_W-1]};
        rem_ge    = rem_ext >= {1'b0, r_y};
        rem_sub   = rem_ext - {1'b0, r_y};
        mul_sum   = r_acc + (r_y[0] ? r_mcand : '0);
        last_step = r_busy && (r_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= last_step;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
            end else if (last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_is_div <= i_ctrl.is_div;
            r_y      <= i_y;
            r_rem    <= '0;
            if (i_ctrl.is_div) begin
                r_cnt <= CNT_W'(DIV_STEPS - 1);
                r_acc <= {i_c, i_x};
            end else begin
                r_cnt <= CNT_W'(MUL_STEPS - 1);
                r_acc <= {{DIGIT_W{1'b0}}, i_c};
            end
            r_mcand <= {{DIGIT_W{1'b0}}, i_x};
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_is_div) begin
                // One quotient bit per cycle; the remainder stays below the divisor.
                r_acc <= {r_acc[2*DIGIT_W-2:0], 1'b0};
                r_rem <= rem_ge ? rem_sub[DIGIT_W-1:0] : rem_ext[DIGIT_W-1:0];
                r_q   <= {r_q[DIGIT_W-2:0], rem_ge};
            end else begin
                r_acc   <= mul_sum;
                r_mcand <= {r_mcand[2*DIGIT_W-2:0], 1'b0};
                r_y     <= {1'b0, r_y[DIGIT_W-1:1]};
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_digit    = r_is_div ? r_q : r_acc[DIGIT_W-1:0];
    assign o_carry    = r_is_div ? r_rem : r_acc[2*DIGIT_W-1:DIGIT_W];

    `ASSERT_CLK(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy), "done without run")
    `ASSERT_NEVER(a_rem_bound, i_clk, i_rst_n, r_busy && r_is_div && (r_rem >= r_y), "remainder too large")

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the multiprecision base-256 digit arithmetic unit.
`timescale 1ns / 1ps

// The bench streams operands into the unit one digit per input beat. It covers
// add with carry, subtract with borrow, negate, multiply by a byte scalar and
// divide by a byte scalar, and it also sends the spare op codes. A small tracker
// class keeps its own copy of the running carry. For every accepted input beat it
// computes the result beat that the unit should return and queues it. Output
// beats are compared field by field against the oldest queued result, in order.
//
// Sender and receiver are plain processes that change the inputs on the falling
// edge. All handshakes are sampled on the rising edge. Both sides draw a random
// idle count for each beat, and some phases run with no idling at all. One phase
// has the receiver hold off for a long stretch while the sender keeps pushing, so
// the output register and the result behind it fill up and the input stalls.
// Between phases the sender waits until every queued result has come back.
module testbench;
    import mda_pkg::*;

    // The op field is three bits wide, so three codes have no operation.
    // The unit must answer them with a zero digit and the held carry.
    localparam logic [2:0] OP_UNUSED_A = 3'd5;
    localparam logic [2:0] OP_UNUSED_B = 3'd6;
    localparam logic [2:0] OP_UNUSED_C = 3'd7;

    localparam int GAP_MAX      = 12;
    localparam int HOLD_CYCLES  = 250;
    localparam int PHASE_BEATS  = 300;
    // The slowest op is a divide. The tail wait leaves room for a stray beat to
    // show up after the queue has drained.
    localparam int TAIL_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_LIMIT = 10;

    // Predicts the unit one beat at a time and holds the results still owed.
    class digit_tracker;
        logic [DIGIT_W-1:0] held_carry;
        t_out               owed_results[$];
        int                 fail_count;

        function new();
            held_carry = '0;
            fail_count = 0;
        endfunction

        function t_out predict_digit(t_in b);
            int unsigned c;
            int unsigned x;
            int unsigned y;
            int unsigned t;
            int unsigned z;
            t_out        r;
            c = held_carry;
            x = b.digit_x;
            y = b.operand_y;
            z = 0;
            r = '0;
            // A first mark reloads the carry. Multiply and divide always start
            // from zero and ignore carry_in. The spare op codes ignore the mark.
            if (b.first && b.op <= OP_DIV) begin
                c = (b.op <= OP_NEG) ? b.carry_in : 0;
            end
            case (b.op)
                OP_ADD: begin
                    t = c + x + y;
                    z = t & 255;
                    c = t >> DIGIT_W;
                end
                OP_SUB: begin
                    // The 3*256 offset keeps the value positive. A borrow of 2
                    // can come out when a large borrow is loaded.
                    t = x + 3 * 256 - y - c;
                    z = t & 255;
                    c = 3 - (t >> DIGIT_W);
                end
                OP_NEG: begin
                    t = c + (255 - x);
                    z = t & 255;
                    c = t >> DIGIT_W;
                end
                OP_MUL: begin
                    t = c + x * y;
                    z = t & 255;
                    c = t >> DIGIT_W;
                end
                OP_DIV: begin
                    if (y == 0) begin
                        z = 255;
                        r.div_error = 1'b1;
                    end else begin
                        // The quotient can pass 255 only when the held carry is not below the
                        // scalar, as when it shrank mid-operand, and then only its low byte is kept.
                        t = (c << DIGIT_W) + x;
                        z = (t / y) & 255;
                        c = t % y;
                    end
                end
                default: begin
                    z = 0;
                end
            endcase
            held_carry  = c[DIGIT_W-1:0];
            r.digit_z   = z[DIGIT_W-1:0];
            r.carry_out = held_carry;
            r.last_out  = b.last;
            return r;
        endfunction

        function void note_operand_beat(t_in b);
            owed_results.push_back(predict_digit(b));
        endfunction

        function void check_result_beat(t_out got);
            t_out want;
            if (owed_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected result beat: digit_z=%0d carry_out=%0d last=%0b err=%0b",
                             got.digit_z, got.carry_out, got.last_out, got.div_error);
                end
                return;
            end
            want = owed_results.pop_front();
            if (got.digit_z !== want.digit_z || got.carry_out !== want.carry_out ||
                got.last_out !== want.last_out || got.div_error !== want.div_error) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("mismatch at %0t: expected z=%0d c=%0d last=%0b err=%0b, got z=%0d c=%0d last=%0b err=%0b",
                             $realtime, want.digit_z, want.carry_out, want.last_out,
                             want.div_error, got.digit_z, got.carry_out, got.last_out,
                             got.div_error);
                end
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  in_valid;
    logic  in_stall;
    t_in   in_data;
    logic  out_valid;
    logic  out_stall;
    t_out  out_data;

    digit_tracker tracker = new();

    // When calm is set, neither side draws an idle count.
    bit calm;
    // Set by the sender. The receiver clears it once its long hold is over.
    bit hold_request;
    int beats_sent;
    int cycle_count = 0;

    multiprecision_digit_alu i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // Both handshakes are sampled here, on the rising edge, outside reset.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                tracker.note_operand_beat(in_data);
            end
            if (out_valid && !out_stall) begin
                tracker.check_result_beat(out_data);
            end
        end
    end

    // This watchdog catches a hung handshake or a result that never comes back.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // Bytes lean toward 0 and 255 so that the carry chains hit their extremes.
    function automatic logic [DIGIT_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return DIGIT_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in digit_beat(logic [2:0] op, logic first, logic last,
                                       logic [7:0] x, logic [7:0] y, logic [7:0] cin);
        t_in b;
        b.op        = op;
        b.first     = first;
        b.last      = last;
        b.digit_x   = x;
        b.operand_y = y;
        b.carry_in  = cin;
        return b;
    endfunction

    // The task idles for a random count, offers one beat and holds it until the
    // unit accepts it. The caller must change in_valid or in_data at the next
    // falling edge, and every path out of here does so.
    task automatic send_beat(t_in b);
        int gap;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge i_clk); while (in_stall !== 1'b0);
        beats_sent++;
    endtask

    // Mostly a well-formed operand with random digits. Now and then the first
    // or last mark is left off, and the multiply or divide scalar is sometimes
    // changed partway through.
    task automatic send_operand();
        t_in        b;
        logic [2:0] op;
        int         len;
        logic [7:0] scalar;
        bit         drop_first;
        bit         drop_last;
        bit         scaled;
        op         = 3'($urandom_range(OP_ADD, OP_DIV));
        len        = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        scalar     = ($urandom_range(0, 15) == 0) ? 8'd0 : pick_byte();
        drop_first = ($urandom_range(0, 19) == 0);
        drop_last  = ($urandom_range(0, 19) == 0);
        scaled     = (op == OP_MUL) || (op == OP_DIV);
        for (int i = 0; i < len; i++) begin
            if (scaled && i > 0 && $urandom_range(0, 15) == 0) begin
                scalar = pick_byte();
            end
            b.op        = op;
            b.first     = (i == 0) && !drop_first;
            b.last      = (i == len - 1) && !drop_last;
            b.digit_x   = pick_byte();
            b.operand_y = scaled ? scalar : pick_byte();
            b.carry_in  = pick_byte();
            send_beat(b);
        end
    endtask

    // A noise beat is random in every field and may carry a spare op code.
    task automatic send_noise();
        t_in b;
        b.op        = 3'($urandom_range(OP_ADD, OP_UNUSED_C));
        b.first     = 1'($urandom_range(0, 1));
        b.last      = 1'($urandom_range(0, 1));
        b.digit_x   = DIGIT_W'($urandom_range(0, 255));
        b.operand_y = DIGIT_W'($urandom_range(0, 255));
        b.carry_in  = DIGIT_W'($urandom_range(0, 255));
        send_beat(b);
    endtask

    task automatic run_phase(int beats);
        int target;
        target = beats_sent + beats;
        while (beats_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                send_noise();
            end else begin
                send_operand();
            end
        end
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // The receiver draws a stall count per result beat. A long hold takes
    // priority when the sender has asked for one.
    initial begin
        int n;
        forever begin
            if (hold_request) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end
            n = draw_gap();
            repeat (n) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
            end
            @(negedge i_clk);
            out_stall <= 1'b0;
            do @(posedge i_clk); while (out_valid !== 1'b1);
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        calm         = 1'b0;
        hold_request = 1'b0;
        beats_sent   = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats. The first is an add with every field at its maximum.
        send_beat(digit_beat(OP_ADD, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255));
        // A two-digit add. The second digit ignores carry_in.
        send_beat(digit_beat(OP_ADD, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
        send_beat(digit_beat(OP_ADD, 1'b0, 1'b1, 8'd255, 8'd255, 8'd200));
        // This subtract loads a borrow above one. The next digit must honor it.
        send_beat(digit_beat(OP_SUB, 1'b1, 1'b0, 8'd0, 8'd255, 8'd255));
        send_beat(digit_beat(OP_SUB, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0));
        send_beat(digit_beat(OP_SUB, 1'b1, 1'b1, 8'd255, 8'd0, 8'd0));
        // Negate, with both digit extremes.
        send_beat(digit_beat(OP_NEG, 1'b1, 1'b0, 8'd0, 8'd0, 8'd1));
        send_beat(digit_beat(OP_NEG, 1'b0, 1'b1, 8'd255, 8'd17, 8'd0));
        // The multiply carry reaches its top value. carry_in is ignored.
        send_beat(digit_beat(OP_MUL, 1'b1, 1'b0, 8'd255, 8'd255, 8'd77));
        send_beat(digit_beat(OP_MUL, 1'b0, 1'b0, 8'd255, 8'd255, 8'd0));
        send_beat(digit_beat(OP_MUL, 1'b0, 1'b1, 8'd0, 8'd0, 8'd255));
        // A divide whose scalar shrinks partway, so the remainder carried in is
        // above the new scalar.
        send_beat(digit_beat(OP_DIV, 1'b1, 1'b0, 8'd200, 8'd250, 8'd99));
        send_beat(digit_beat(OP_DIV, 1'b0, 1'b0, 8'd255, 8'd3, 8'd0));
        send_beat(digit_beat(OP_DIV, 1'b0, 1'b1, 8'd0, 8'd255, 8'd0));
        // Zero divisor, on a first beat and then on a continuing one.
        send_beat(digit_beat(OP_DIV, 1'b1, 1'b0, 8'd10, 8'd0, 8'd0));
        send_beat(digit_beat(OP_DIV, 1'b0, 1'b1, 8'd7, 8'd0, 8'd0));
        // Spare op codes. Their first mark must not reload the carry.
        send_beat(digit_beat(OP_MUL, 1'b1, 1'b0, 8'd255, 8'd200, 8'd0));
        send_beat(digit_beat(OP_UNUSED_A, 1'b1, 1'b1, 8'd1, 8'd2, 8'd3));
        send_beat(digit_beat(OP_UNUSED_B, 1'b0, 1'b0, 8'd255, 8'd255, 8'd255));
        send_beat(digit_beat(OP_UNUSED_C, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0));
        // Without a first mark, the add continues from the held carry.
        send_beat(digit_beat(OP_ADD, 1'b0, 1'b1, 8'd1, 8'd1, 8'd0));
        send_beat(digit_beat(OP_MUL, 1'b1, 1'b1, 8'd0, 8'd255, 8'd255));
        send_beat(digit_beat(OP_DIV, 1'b1, 1'b1, 8'd255, 8'd1, 8'd255));
        pause_until_drained();

        run_phase(PHASE_BEATS);
        pause_until_drained();

        calm = 1'b1;
        run_phase(PHASE_BEATS);
        pause_until_drained();

        // The receiver holds off for a long stretch while beats keep coming.
        hold_request = 1'b1;
        run_phase(PHASE_BEATS);
        calm = 1'b0;
        pause_until_drained();

        run_phase(PHASE_BEATS);
        pause_until_drained();

        calm = 1'b1;
        run_phase(PHASE_BEATS / 2);
        calm = 1'b0;
        run_phase(PHASE_BEATS / 2);
        pause_until_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.fail_count == 0 && tracker.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mda_pkg.sv
hw/rtl/mda_digit_add.sv
hw/rtl/mda_shift_unit.sv
hw/rtl/multiprecision_digit_alu.sv
bench/testbench.sv
